### rtl/dmwc_pkg.sv
// Shared types, constants and the microcode ROM of the dual lag-2 multiply-with-carry
// generator. No dependencies; imported by the top level.
package dmwc_pkg;

   localparam int WORD_W         = 32;
   localparam int VALUE_W        = 64;
   localparam int IDX_W          = 3;
   localparam int NUM_WORDS      = 6;
   localparam int SEED_MAX_ITER  = 12;
   localparam int WARMUP_DEFAULT = 13;
   localparam int UPC_W          = 4;

   // Generator multipliers and seeding constants
   localparam logic [WORD_W-1:0]  MUL_A1 = 32'd4293538899;
   localparam logic [WORD_W-1:0]  MUL_A2 = 32'd4291750983;
   localparam logic [WORD_W-1:0]  LCG_Z3 = 32'd3571494541;
   localparam logic [WORD_W-1:0]  LCG_Z4 = 32'd3753453877;
   localparam logic [VALUE_W-1:0] LCG_Z5 = 64'd18277323205306182053;
   localparam logic [WORD_W-1:0]  MASK31 = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0]  MASK30 = 32'h3FFF_FFFF;

   typedef enum logic [1:0] {
      CMD_NEXT   = 2'd0,
      CMD_RESEED = 2'd1,
      CMD_WRITE  = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      OP_NOP       = 4'd0,
      OP_MWC_STEP  = 4'd1,
      OP_SUM       = 4'd2,
      OP_ACCESS    = 4'd3,
      OP_LCG_START = 4'd4,
      OP_LCG_ADD   = 4'd5,
      OP_LCG_MUL   = 4'd6,
      OP_LCG_ACC   = 4'd7,
      OP_LOAD      = 4'd8,
      OP_WARM      = 4'd9,
      OP_DONE      = 4'd10
   } uop_type;

   typedef enum logic [2:0] {
      COND_NEXT      = 3'd0,
      COND_JUMP      = 3'd1,
      COND_DISPATCH  = 3'd2,
      COND_SEED_MORE = 3'd3,
      COND_WARM_MORE = 3'd4
   } cond_type;

   typedef struct packed {
      uop_type           op;
      cond_type          cond;
      logic              first;   // select the first-round seeding constants
      logic [UPC_W-1:0]  target;
   } ucode_type;

   // Microprogram entry points
   localparam logic [UPC_W-1:0] UA_IDLE     = 4'd0;
   localparam logic [UPC_W-1:0] UA_NEXT     = 4'd1;
   localparam logic [UPC_W-1:0] UA_SUM      = 4'd2;
   localparam logic [UPC_W-1:0] UA_ACCESS   = 4'd3;
   localparam logic [UPC_W-1:0] UA_RESEED   = 4'd4;
   localparam logic [UPC_W-1:0] UA_MUL0     = 4'd5;
   localparam logic [UPC_W-1:0] UA_ACC0     = 4'd6;
   localparam logic [UPC_W-1:0] UA_LCG_LOOP = 4'd7;
   localparam logic [UPC_W-1:0] UA_LCG_MUL  = 4'd8;
   localparam logic [UPC_W-1:0] UA_LCG_ACC  = 4'd9;
   localparam logic [UPC_W-1:0] UA_LOAD     = 4'd10;
   localparam logic [UPC_W-1:0] UA_WARM     = 4'd11;
   localparam logic [UPC_W-1:0] UA_DONE     = 4'd12;

   function automatic ucode_type ucode_fetch(logic [UPC_W-1:0] upc);
      ucode_type w;
      w = '{op: OP_NOP, cond: COND_JUMP, first: 1'b0, target: UA_IDLE};
      unique case (upc)
         UA_IDLE:     w = '{op: OP_NOP,       cond: COND_DISPATCH,  first: 1'b0,
                            target: UA_IDLE};
         UA_NEXT:     w = '{op: OP_MWC_STEP,  cond: COND_NEXT,      first: 1'b0,
                            target: UA_IDLE};
         UA_SUM:      w = '{op: OP_SUM,       cond: COND_JUMP,      first: 1'b0,
                            target: UA_IDLE};
         UA_ACCESS:   w = '{op: OP_ACCESS,    cond: COND_JUMP,      first: 1'b0,
                            target: UA_IDLE};
         UA_RESEED:   w = '{op: OP_LCG_START, cond: COND_NEXT,      first: 1'b1,
                            target: UA_IDLE};
         UA_MUL0:     w = '{op: OP_LCG_MUL,   cond: COND_NEXT,      first: 1'b1,
                            target: UA_IDLE};
         UA_ACC0:     w = '{op: OP_LCG_ACC,   cond: COND_NEXT,      first: 1'b1,
                            target: UA_IDLE};
         UA_LCG_LOOP: w = '{op: OP_LCG_ADD,   cond: COND_NEXT,      first: 1'b0,
                            target: UA_IDLE};
         UA_LCG_MUL:  w = '{op: OP_LCG_MUL,   cond: COND_NEXT,      first: 1'b0,
                            target: UA_IDLE};
         UA_LCG_ACC:  w = '{op: OP_LCG_ACC,   cond: COND_SEED_MORE, first: 1'b0,
                            target: UA_LCG_LOOP};
         UA_LOAD:     w = '{op: OP_LOAD,      cond: COND_NEXT,      first: 1'b0,
                            target: UA_IDLE};
         UA_WARM:     w = '{op: OP_WARM,      cond: COND_WARM_MORE, first: 1'b0,
                            target: UA_WARM};
         UA_DONE:     w = '{op: OP_DONE,      cond: COND_JUMP,      first: 1'b0,
                            target: UA_IDLE};
         default:     w = '{op: OP_NOP,       cond: COND_JUMP,      first: 1'b0,
                            target: UA_IDLE};
      endcase
      return w;
   endfunction

endpackage

### rtl/dual_mwc_lag2_random_generator.sv
// Top level of the dual lag-2 multiply-with-carry generator: microcode sequencer,
// state words, seeding datapath and result registers. Depends on dmwc_pkg.
//
//   channel   ports                                        handshake
//   --------  -------------------------------------------  ------------------------------
//   request   req_cmd, req_word_index, req_word_data       taken when start && !busy
//   result    rsp_value, rsp_bad_index                     rsp_strobe, one cycle, no stall
//   config    csr_write_data                               csr_write_enable, write only
//
// Sequence: a next value runs a generator step, then the sum; a read or write of a state
// word runs the access step; a new transaction is taken in the strobe cycle. Reseed runs
// the LCG start and the first-round multiply and accumulate, then 6 to 12 seeding rounds,
// the load, WARMUP_STEPS warm-up steps and done, one microcode step per cycle; a seeding
// round splits its 64-bit multiply into two 32x32 products and spends three steps.
// Reset: synchronous; after reset the block runs a reseed from seed 0 with busy high
// and no result. Results cannot be stalled: each one is shown for one cycle only.
module dual_mwc_lag2_random_generator #(
   parameter int WARMUP_STEPS = dmwc_pkg::WARMUP_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_cmd,
   input  logic [dmwc_pkg::IDX_W-1:0]    req_word_index,
   input  logic [dmwc_pkg::WORD_W-1:0]   req_word_data,
   output logic                          rsp_strobe,
   output logic [dmwc_pkg::VALUE_W-1:0]  rsp_value,
   output logic                          rsp_bad_index,
   input  logic                          csr_write_enable,
   input  logic [dmwc_pkg::VALUE_W-1:0]  csr_write_data
);
   import dmwc_pkg::*;

   // Warm-up counter holds 0..WARMUP_STEPS
   localparam int WARM_W = $clog2(WARMUP_STEPS + 2);

   // Sequencer
   logic [UPC_W-1:0]    upc_ff, upc_in;
   logic                auto_ff, auto_in;      // reseed launched by reset: no result
   ucode_type           uw;
   logic                accept;

   // Configuration and captured transaction
   logic [VALUE_W-1:0]  seed_ff, seed_in;
   cmd_type             cmd_ff, cmd_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [WORD_W-1:0]   data_ff, data_in;

   // Generator state: gen1 old/new/carry, gen2 old/new/carry
   logic [WORD_W-1:0]   words_ff [NUM_WORDS];
   logic [WORD_W-1:0]   words_in [NUM_WORDS];
   logic [VALUE_W-1:0]  x1_ff, x1_in;
   logic [VALUE_W-1:0]  x2_ff, x2_in;

   // Seeding datapath
   logic [VALUE_W-1:0]  y_ff, y_in;
   logic [VALUE_W-1:0]  plo_ff, plo_in;
   logic [WORD_W-1:0]   phi_ff, phi_in;
   logic [VALUE_W-1:0]  x_ff, x_in;
   logic [WORD_W-1:0]   z_ff [NUM_WORDS];
   logic [WORD_W-1:0]   z_in [NUM_WORDS];
   logic [2:0]          kept_ff, kept_in;
   logic [3:0]          iter_ff, iter_in;
   logic [WARM_W-1:0]   warm_ff, warm_in;

   // Result registers
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                rsp_bad_ff, rsp_bad_in;

   // Combinational helpers
   logic [VALUE_W-1:0]  mwc_x1, mwc_x2;
   logic [WORD_W-1:0]   lcg_mul_k;
   logic [VALUE_W-1:0]  lcg_hi_full;
   logic [VALUE_W-1:0]  lcg_addend;
   logic [VALUE_W-1:0]  lcg_acc;
   logic                lcg_keep;
   logic [3:0]          iter_next;
   logic [2:0]          kept_next;
   logic                seed_more;
   logic                warm_more;
   logic                mwc_en;
   logic                idx_bad;

   assign uw     = ucode_fetch(upc_ff);
   assign busy   = (upc_ff != UA_IDLE);
   assign accept = start && !busy;

   // One generator step: 32x32 product plus carry for each half
   assign mwc_x1 = words_ff[0] * MUL_A1 + {32'd0, words_ff[2]};
   assign mwc_x2 = words_ff[3] * MUL_A2 + {32'd0, words_ff[5]};

   // Seeding LCG: y * k mod 2^64 from two 32x32 products, then add the offset
   assign lcg_mul_k   = uw.first ? LCG_Z4 : LCG_Z3;
   assign lcg_hi_full = y_ff[63:32] * lcg_mul_k;
   assign lcg_addend  = uw.first ? LCG_Z5 : {32'd0, LCG_Z4};
   assign lcg_acc     = plo_ff + {phi_ff, 32'd0} + lcg_addend;
   assign lcg_keep    = (lcg_acc[29:0] != 30'd0);
   assign iter_next   = iter_ff + 4'd1;
   assign kept_next   = lcg_keep ? kept_ff + 3'd1 : kept_ff;
   assign seed_more   = (iter_next < 4'(SEED_MAX_ITER)) && (kept_next < 3'(NUM_WORDS));

   assign warm_more = (warm_ff != WARM_W'(WARMUP_STEPS));
   assign mwc_en    = (uw.op == OP_MWC_STEP) || ((uw.op == OP_WARM) && warm_more);
   assign idx_bad   = (idx_ff >= IDX_W'(NUM_WORDS));

   // Step counter: fall through, jump, loop, or dispatch on the incoming command
   always_comb begin
      upc_in = upc_ff;
      unique case (uw.cond)
         COND_NEXT:      upc_in = upc_ff + 4'd1;
         COND_JUMP:      upc_in = uw.target;
         COND_DISPATCH: begin
            if (accept) begin
               unique case (cmd_type'(req_cmd))
                  CMD_NEXT:   upc_in = UA_NEXT;
                  CMD_RESEED: upc_in = UA_RESEED;
                  CMD_WRITE,
                  CMD_READ:   upc_in = UA_ACCESS;
                  default:    upc_in = UA_IDLE;
               endcase
            end
         end
         COND_SEED_MORE: upc_in = seed_more ? uw.target : upc_ff + 4'd1;
         COND_WARM_MORE: upc_in = warm_more ? uw.target : upc_ff + 4'd1;
         default:        upc_in = UA_IDLE;
      endcase
   end

   // Datapath controlled by the current control word
   always_comb begin
      auto_in       = auto_ff;
      seed_in       = csr_write_enable ? csr_write_data : seed_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      data_in       = data_ff;
      words_in      = words_ff;
      x1_in         = x1_ff;
      x2_in         = x2_ff;
      y_in          = y_ff;
      plo_in        = plo_ff;
      phi_in        = phi_ff;
      x_in          = x_ff;
      z_in          = z_ff;
      kept_in       = kept_ff;
      iter_in       = iter_ff;
      warm_in       = warm_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_bad_in    = rsp_bad_ff;

      // Capture the transaction at dispatch
      if (accept) begin
         cmd_in  = cmd_type'(req_cmd);
         idx_in  = req_word_index;
         data_in = req_word_data;
      end

      // Shift the lags and store the new word and carry
      if (mwc_en) begin
         words_in[0] = words_ff[1];
         words_in[1] = mwc_x1[31:0];
         words_in[2] = mwc_x1[63:32];
         words_in[3] = words_ff[4];
         words_in[4] = mwc_x2[31:0];
         words_in[5] = mwc_x2[63:32];
         x1_in       = mwc_x1;
         x2_in       = mwc_x2;
      end

      case (uw.op)
         OP_SUM: begin
            rsp_strobe_in = 1'b1;
            rsp_value_in  = x1_ff + {x2_ff[31:0], x2_ff[63:32]};
            rsp_bad_in    = 1'b0;
         end
         OP_ACCESS: begin
            rsp_strobe_in = 1'b1;
            rsp_value_in  = '0;
            rsp_bad_in    = idx_bad;
            if (!idx_bad) begin
               if (cmd_ff == CMD_WRITE) begin
                  words_in[idx_ff] = data_ff;
               end else begin
                  rsp_value_in = {32'd0, words_ff[idx_ff]};
               end
            end
         end
         OP_LCG_START: begin
            y_in    = {32'd0, LCG_Z3} + seed_ff;
            kept_in = '0;
            iter_in = '0;
            for (int i = 0; i < NUM_WORDS; i++) begin
               z_in[i] = '0;
            end
         end
         OP_LCG_ADD: y_in = x_ff + seed_ff;
         OP_LCG_MUL: begin
            plo_in = y_ff[31:0] * lcg_mul_k;
            phi_in = lcg_hi_full[31:0];
         end
         OP_LCG_ACC: begin
            x_in = lcg_acc;
            if (!uw.first) begin
               iter_in = iter_next;
               kept_in = kept_next;
               if (lcg_keep) begin
                  z_in[kept_ff] = lcg_acc[31:0];
               end
            end
         end
         OP_LOAD: begin
            // Kept words go in reverse order, masked to 31 or 30 bits
            words_in[0] = z_ff[5] & MASK31;
            words_in[1] = z_ff[4] & MASK31;
            words_in[2] = z_ff[3] & MASK30;
            words_in[3] = z_ff[2] & MASK31;
            words_in[4] = z_ff[1] & MASK31;
            words_in[5] = z_ff[0] & MASK30;
            warm_in     = '0;
         end
         OP_WARM: begin
            if (warm_more) begin
               warm_in = warm_ff + WARM_W'(1);
            end
         end
         OP_DONE: begin
            // Report a commanded reseed; drop the result of the one after reset
            rsp_strobe_in = !auto_ff;
            rsp_value_in  = '0;
            rsp_bad_in    = 1'b0;
            auto_in       = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff        <= UA_RESEED;
         auto_ff       <= 1'b1;
         seed_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         upc_ff        <= upc_in;
         auto_ff       <= auto_in;
         seed_ff       <= seed_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      data_ff      <= data_in;
      words_ff     <= words_in;
      x1_ff        <= x1_in;
      x2_ff        <= x2_in;
      y_ff         <= y_in;
      plo_ff       <= plo_in;
      phi_ff       <= phi_in;
      x_ff         <= x_in;
      z_ff         <= z_in;
      kept_ff      <= kept_in;
      iter_ff      <= iter_in;
      warm_ff      <= warm_in;
      rsp_value_ff <= rsp_value_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_bad_index = rsp_bad_ff;

endmodule

### rtl/dmwc_checker.sv
// Port-level checks for the dual lag-2 multiply-with-carry generator, and the bind
// that attaches them to the top level. No package dependencies.
module dmwc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [63:0] rsp_value,
   input logic        rsp_bad_index
);

   // An accepted transaction makes the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy low right after an accepted transaction");

   // A result only appears as the block goes idle
   a_strobe_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // Results are never shown in two adjacent cycles
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe in two adjacent cycles");

   // A rejected index returns zero
   a_bad_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_bad_index |-> rsp_value == 64'd0)
      else $error("nonzero value with bad index");

   // Reset launches the automatic reseed
   a_reseed_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> busy)
      else $error("not busy after reset");

endmodule

bind dual_mwc_lag2_random_generator dmwc_checker u_dmwc_checker (.*);
